>>> rtl/fifo_with_replace_all_top_macros.svh
// Assertion macros for the replace-all FIFO checker
`ifndef FIFO_WITH_REPLACE_ALL_TOP_MACROS_SVH
`define FIFO_WITH_REPLACE_ALL_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FWRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FWRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/fwra_pkg.sv
// Types, codes and microcode ROM for the replace-all FIFO
`default_nettype none
package fwra_pkg;

	localparam int DEPTH_DEF = 512;
	localparam int STEP_W    = 4;

	localparam logic [1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [1:0] ACT_DEQUEUE = 2'd1;
	localparam logic [1:0] ACT_REPLACE = 2'd2;
	localparam logic [1:0] ACT_CLEAR   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [1:0] C_NONE  = 2'd0;
	localparam logic [1:0] C_FULL  = 2'd1;
	localparam logic [1:0] C_EMPTY = 2'd2;
	localparam logic [1:0] C_LAST  = 2'd3;

	localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_RESP   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_ENQ    = 4'd2;
	localparam logic [STEP_W-1:0] STEP_DEQ    = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DEQ2   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_REP    = 4'd5;
	localparam logic [STEP_W-1:0] STEP_REP_RD = 4'd6;
	localparam logic [STEP_W-1:0] STEP_REP_WR = 4'd7;
	localparam logic [STEP_W-1:0] STEP_CLR    = 4'd8;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] value;
		logic signed [31:0] new_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		logic [1:0]         status;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	typedef struct packed {
		logic              accept;
		logic              emit;
		logic              guard;
		logic [1:0]        cond;
		logic [1:0]        err;
		logic              rd_head;
		logic              rd_idx;
		logic              wr_tail;
		logic              wr_idx;
		logic              head_inc;
		logic              tail_inc;
		logic              occ_inc;
		logic              occ_dec;
		logic              walk_load;
		logic              walk_step;
		logic              clr;
		logic              cap_data;
		logic [STEP_W-1:0] jmp;
		logic [STEP_W-1:0] nxt;
	} ucode_t;

	function automatic logic [STEP_W-1:0] dispatch(input logic [1:0] action);
		logic [STEP_W-1:0] s;
		unique case (action)
			ACT_ENQUEUE: s = STEP_ENQ;
			ACT_DEQUEUE: s = STEP_DEQ;
			ACT_REPLACE: s = STEP_REP;
			ACT_CLEAR:   s = STEP_CLR;
		endcase
		return s;
	endfunction

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '0;
		unique case (step)
			STEP_RESP: begin
				w.accept = 1'b1;
				w.emit   = 1'b1;
			end
			STEP_ENQ: begin
				w.guard    = 1'b1;
				w.cond     = C_FULL;
				w.err      = ST_FULL;
				w.wr_tail  = 1'b1;
				w.tail_inc = 1'b1;
				w.occ_inc  = 1'b1;
				w.jmp      = STEP_RESP;
				w.nxt      = STEP_RESP;
			end
			STEP_DEQ: begin
				w.guard   = 1'b1;
				w.cond    = C_EMPTY;
				w.err     = ST_EMPTY;
				w.rd_head = 1'b1;
				w.jmp     = STEP_RESP;
				w.nxt     = STEP_DEQ2;
			end
			STEP_DEQ2: begin
				w.cap_data = 1'b1;
				w.head_inc = 1'b1;
				w.occ_dec  = 1'b1;
				w.nxt      = STEP_RESP;
			end
			STEP_REP: begin
				w.guard     = 1'b1;
				w.cond      = C_EMPTY;
				w.err       = ST_OK;
				w.walk_load = 1'b1;
				w.jmp       = STEP_RESP;
				w.nxt       = STEP_REP_RD;
			end
			STEP_REP_RD: begin
				w.rd_idx = 1'b1;
				w.nxt    = STEP_REP_WR;
			end
			STEP_REP_WR: begin
				w.cond      = C_LAST;
				w.wr_idx    = 1'b1;
				w.walk_step = 1'b1;
				w.jmp       = STEP_RESP;
				w.nxt       = STEP_REP_RD;
			end
			STEP_CLR: begin
				w.clr = 1'b1;
				w.nxt = STEP_RESP;
			end
			default: begin
				w.accept = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

>>> rtl/fifo_with_replace_all_top.sv
// Replace-all FIFO: microcoded sequencer over a ring buffer memory
// Steps: enqueue ENQ, RESP; clear CLR, RESP; dequeue DEQ, DEQ2, RESP; replace REP, then
// REP_RD and REP_WR per entry (one memory read and one conditional write per entry), RESP;
// DEQ and REP go to RESP when empty. A request is taken only when idle or in RESP with the
// response register free, never mid-request; the single-port memory walk sets replace time.
// Reset clears the step counter, pointers, count and output valid; slot contents are kept.
`default_nettype none
module fifo_with_replace_all_top
	import fwra_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire logic req_valid,
	output logic      req_stall,
	output rsp_t      rsp,
	output logic      rsp_valid,
	input  wire logic rsp_stall
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	logic [STEP_W-1:0] pc_q;
	ucode_t            uw;
	req_t              req_q;
	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;
	logic signed [31:0] data_q;
	logic [1:0]        stat_q;
	logic [IDX_W-1:0]  head_q, tail_q, widx_q;
	logic [OCC_W-1:0]  occ_q, wcnt_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	logic              full, empty, last, cond_hit, exec, out_free, go;
	logic [IDX_W-1:0]  head_nx, tail_nx, widx_nx, rd_addr;

	assign uw       = ucode_rom(pc_q);
	assign full     = (occ_q == OCC_W'(DEPTH));
	assign empty    = (occ_q == '0);
	assign last     = (wcnt_q == OCC_W'(1));
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign go       = uw.accept && (!uw.emit || out_free);
	assign head_nx  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign tail_nx  = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + IDX_W'(1);
	assign widx_nx  = (widx_q == IDX_W'(DEPTH - 1)) ? '0 : widx_q + IDX_W'(1);
	assign rd_addr  = uw.rd_head ? head_q : widx_q;

	always_comb begin
		unique case (uw.cond)
			C_NONE:  cond_hit = 1'b0;
			C_FULL:  cond_hit = full;
			C_EMPTY: cond_hit = empty;
			C_LAST:  cond_hit = last;
		endcase
	end

	assign exec      = !(uw.guard && cond_hit);
	assign req_stall = !go;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (uw.accept) begin
				if (go) begin
					pc_q <= req_valid ? dispatch(req.action) : STEP_IDLE;
				end
			end else begin
				pc_q <= cond_hit ? uw.jmp : uw.nxt;
			end
			if (exec && uw.head_inc) begin
				head_q <= head_nx;
			end
			if (exec && uw.tail_inc) begin
				tail_q <= tail_nx;
			end
			if (exec && uw.occ_inc) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (exec && uw.occ_dec) begin
				occ_q <= occ_q - OCC_W'(1);
			end
			if (uw.clr) begin
				head_q <= '0;
				tail_q <= '0;
				occ_q  <= '0;
			end
			if (go && uw.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && req_valid) begin
			req_q  <= req;
			stat_q <= ST_OK;
			data_q <= '0;
		end
		if (uw.guard && cond_hit) begin
			stat_q <= uw.err;
		end
		if (uw.cap_data) begin
			data_q <= rdata_q;
		end
		if (exec && uw.walk_load) begin
			widx_q <= head_q;
			wcnt_q <= occ_q;
		end else if (uw.walk_step) begin
			widx_q <= widx_nx;
			wcnt_q <= wcnt_q - OCC_W'(1);
		end
		if (go && uw.emit) begin
			rsp_q.data_out <= data_q;
			rsp_q.status   <= stat_q;
			rsp_q.is_empty <= empty;
			rsp_q.is_full  <= full;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && (uw.rd_head || uw.rd_idx)) begin
			rdata_q <= mem[rd_addr];
		end
		if (exec && uw.wr_tail) begin
			mem[tail_q] <= req_q.value;
		end else if (uw.wr_idx && (rdata_q == req_q.value)) begin
			mem[widx_q] <= req_q.new_value;
		end
	end

endmodule
`default_nettype wire

>>> rtl/fwra_checker.sv
// Port-level checker for the replace-all FIFO and its bind
`default_nettype none
`include "fifo_with_replace_all_top_macros.svh"
module fwra_checker
	import fwra_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire req_t req,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire rsp_t rsp,
	input wire logic rsp_valid,
	input wire logic rsp_stall
);

	`FWRA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
	`FWRA_ASSERT_NOW(a_flags, rsp_valid, !(rsp.is_empty && rsp.is_full), "empty and full together")
	`FWRA_ASSERT_NOW(a_status, rsp_valid, rsp.status == ST_OK || rsp.status == ST_FULL || rsp.status == ST_EMPTY, "bad status code")
	`FWRA_ASSERT_NOW(a_err_data, rsp_valid && rsp.status != ST_OK, rsp.data_out == '0, "data on rejected request")
	`FWRA_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall, "request taken while busy")

endmodule

bind fifo_with_replace_all_top fwra_checker u_fwra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req       (req),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp       (rsp),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall)
);
`default_nettype wire

>>> tb/fifo_with_replace_all_checker.sv
// Request/response monitor with ring-buffer prediction and in-order compare for the FIFO
`timescale 1ns / 1ps
module fifo_with_replace_all_checker
	import fwra_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	input  logic req_stall,
	input  rsp_t rsp,
	input  logic rsp_valid,
	input  logic rsp_stall,
	output int   fail_count,
	output int   outstanding,
	output int   result_count,
	output int   full_rejects,
	output int   empty_rejects
);

	logic [31:0] ring_slots [DEPTH];
	int unsigned head_ptr;
	int unsigned tail_ptr;
	int unsigned held;
	rsp_t        pending_rsps [$];
	int          errs;
	int          n_results;
	int          n_full;
	int          n_empty;

	initial begin
		fail_count    = 0;
		outstanding   = 0;
		result_count  = 0;
		full_rejects  = 0;
		empty_rejects = 0;
		errs          = 0;
		n_results     = 0;
		n_full        = 0;
		n_empty       = 0;
		head_ptr      = 0;
		tail_ptr      = 0;
		held          = 0;
	end

	function automatic rsp_t apply_action(input req_t r);
		rsp_t        o;
		int unsigned idx;
		int unsigned i;
		o = '0;
		case (r.action)
			ACT_ENQUEUE: begin
				if (held >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					ring_slots[tail_ptr] = r.value;
					tail_ptr = (tail_ptr + 1) % DEPTH;
					held++;
				end
			end
			ACT_DEQUEUE: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.data_out = ring_slots[head_ptr];
					head_ptr = (head_ptr + 1) % DEPTH;
					held--;
				end
			end
			ACT_REPLACE: begin
				idx = head_ptr;
				for (i = 0; i < held; i++) begin
					if (ring_slots[idx] == r.value)
						ring_slots[idx] = r.new_value;
					idx = (idx + 1) % DEPTH;
				end
			end
			ACT_CLEAR: begin
				head_ptr = 0;
				tail_ptr = 0;
				held     = 0;
			end
			default: begin
			end
		endcase
		o.is_empty = (held == 0);
		o.is_full  = (held >= DEPTH);
		return o;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			head_ptr = 0;
			tail_ptr = 0;
			held     = 0;
			pending_rsps.delete();
		end else begin
			// response first, so a stray one never pairs with a request taken this edge
			if (rsp_valid && !rsp_stall) begin
				n_results++;
				if (pending_rsps.size() == 0) begin
					$display("%0t ns: response with nothing expected, got %h", $time, rsp);
					errs++;
				end else begin
					want = pending_rsps.pop_front();
					if (rsp.data_out !== want.data_out)
						report_mismatch("data_out", want.data_out, rsp.data_out);
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(rsp.status));
					if (rsp.is_empty !== want.is_empty)
						report_mismatch("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
					if (rsp.is_full !== want.is_full)
						report_mismatch("is_full", 32'(want.is_full), 32'(rsp.is_full));
				end
			end
			if (req_valid && !req_stall) begin
				want = apply_action(req);
				if (want.status == ST_FULL)
					n_full++;
				if (want.status == ST_EMPTY)
					n_empty++;
				pending_rsps.push_back(want);
			end
		end
		fail_count    <= errs;
		outstanding   <= pending_rsps.size();
		result_count  <= n_results;
		full_rejects  <= n_full;
		empty_rejects <= n_empty;
	end

endmodule

>>> tb/tb_fifo_with_replace_all_top.sv
// Stimulus, pacing and verdict for the replace-all FIFO testbench
`timescale 1ns / 1ps
module tb_fifo_with_replace_all_top;
	import fwra_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 40;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	req_t req       = '0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	rsp_t rsp;
	logic rsp_valid;

	int fail_count;
	int outstanding;
	int result_count;
	int full_rejects;
	int empty_rejects;

	int cycle_count = 0;
	int sent_count  = 0;
	int level       = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	logic [31:0] value_pool [8];

	fifo_with_replace_all_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	fifo_with_replace_all_checker #(.DEPTH(DEPTH_DEF)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.rsp           (rsp),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.result_count  (result_count),
		.full_rejects  (full_rejects),
		.empty_rejects (empty_rejects)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall   <= ($urandom_range(0, 99) < stall_pct);
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// pool values make replace hits likely
	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 1))
			return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	task automatic send_req(input logic [1:0] act, input logic [31:0] v,
			input logic [31:0] nv);
		req_t r;
		r.action    = act;
		r.value     = v;
		r.new_value = nv;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_count++;
		case (act)
			ACT_ENQUEUE: if (level < DEPTH_DEF) level++;
			ACT_DEQUEUE: if (level > 0) level--;
			ACT_CLEAR:   level = 0;
			default: begin
			end
		endcase
		if ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic run_mix(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 42)
				send_req(ACT_ENQUEUE, pick_value(), $urandom());
			else if (r < 78)
				send_req(ACT_DEQUEUE, $urandom(), $urandom());
			else if (r < 94)
				send_req(ACT_REPLACE, pick_value(), pick_value());
			else
				send_req(ACT_CLEAR, $urandom(), $urandom());
		end
	endtask

	// fill to capacity, push past it, replace while full, wrap both pointers
	task automatic run_fill();
		while (level < DEPTH_DEF)
			send_req(ACT_ENQUEUE, pick_value(), $urandom());
		repeat (3) send_req(ACT_ENQUEUE, $urandom(), $urandom());
		repeat (2) send_req(ACT_REPLACE, value_pool[$urandom_range(0, 7)], $urandom());
		repeat (200) send_req(ACT_DEQUEUE, $urandom(), $urandom());
		repeat (201) send_req(ACT_ENQUEUE, pick_value(), $urandom());
		send_req(ACT_REPLACE, value_pool[$urandom_range(0, 7)], pick_value());
		repeat (300) send_req(ACT_DEQUEUE, $urandom(), $urandom());
		send_req(ACT_CLEAR, $urandom(), $urandom());
	endtask

	initial begin
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, extremes, replace hit/miss, clear
		send_req(ACT_DEQUEUE, 32'h0, 32'h0);
		send_req(ACT_REPLACE, 32'h0, 32'hffff_ffff);
		send_req(ACT_ENQUEUE, 32'h7fff_ffff, 32'h0);
		send_req(ACT_ENQUEUE, 32'h8000_0000, 32'h0);
		send_req(ACT_ENQUEUE, 32'h0000_0000, 32'h0);
		send_req(ACT_ENQUEUE, 32'hffff_ffff, 32'h0);
		send_req(ACT_ENQUEUE, 32'h8000_0000, 32'h0);
		send_req(ACT_REPLACE, 32'h8000_0000, 32'h7fff_ffff);
		send_req(ACT_REPLACE, 32'd12345, 32'd1);
		repeat (3) send_req(ACT_DEQUEUE, 32'h0, 32'h0);
		send_req(ACT_REPLACE, 32'hffff_ffff, 32'h8000_0000);
		repeat (3) send_req(ACT_DEQUEUE, 32'hffff_ffff, 32'hffff_ffff);
		send_req(ACT_ENQUEUE, 32'h5555_5555, 32'haaaa_aaaa);
		send_req(ACT_ENQUEUE, 32'haaaa_aaaa, 32'h5555_5555);
		send_req(ACT_CLEAR, 32'h0, 32'h0);
		send_req(ACT_DEQUEUE, 32'h0, 32'h0);
		send_req(ACT_ENQUEUE, 32'd7, 32'h0);
		send_req(ACT_DEQUEUE, 32'h0, 32'h0);
		wait_drained();

		idle_pct = 13;
		stall_pct <= 60;
		run_mix(300);
		run_fill();
		wait_drained();

		idle_pct = 60;
		stall_pct <= 13;
		run_mix(300);
		wait_drained();

		idle_pct = 0;
		stall_pct <= 0;
		run_mix(300);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d responses over three pacing phases",
			sent_count, result_count);
		$display("Saw %0d full rejections and %0d empty rejections, one fill with ring wrap",
			full_rejects, empty_rejects);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
